/* rtl/atapio_pkg.sv */
package atapio_pkg;

    localparam int ADDR_W = 48;
    localparam int CFG_W = 48;
    localparam int SPC_W = 13;
    localparam int PC_W = 5;
    localparam int STEP_W = 6;

    localparam logic [STEP_W-1:0] DIV_LONG_STEPS = 6'd48;
    localparam logic [STEP_W-1:0] DIV_SHORT_STEPS = 6'd13;

    localparam logic [2:0] CFG_DRIVE0_MODE = 3'd0;
    localparam logic [2:0] CFG_DRIVE1_MODE = 3'd1;
    localparam logic [2:0] CFG_DRIVE0_CAPACITY = 3'd2;
    localparam logic [2:0] CFG_DRIVE1_CAPACITY = 3'd3;
    localparam logic [2:0] CFG_DRIVE0_HEADS = 3'd4;
    localparam logic [2:0] CFG_DRIVE0_TRACK_SECTORS = 3'd5;
    localparam logic [2:0] CFG_DRIVE1_HEADS = 3'd6;
    localparam logic [2:0] CFG_DRIVE1_TRACK_SECTORS = 3'd7;

    localparam logic [1:0] MODE_CHS = 2'd0;
    localparam logic [1:0] MODE_LBA28 = 2'd1;

    localparam logic [2:0] TF_NONE = 3'd0;
    localparam logic [2:0] TF_SECCOUNT = 3'd2;
    localparam logic [2:0] TF_LBA_LO = 3'd3;
    localparam logic [2:0] TF_LBA_MID = 3'd4;
    localparam logic [2:0] TF_LBA_HI = 3'd5;
    localparam logic [2:0] TF_DRIVE_HEAD = 3'd6;
    localparam logic [2:0] TF_COMMAND = 3'd7;

    localparam logic [7:0] DH_MASTER = 8'ha0;
    localparam logic [7:0] DH_SLAVE = 8'hb0;
    localparam logic [7:0] DH_LBA = 8'h40;
    localparam logic [7:0] CMD_READ_EXT = 8'h24;
    localparam logic [7:0] CMD_READ = 8'h20;

    localparam logic [1:0] SEL_NONE = 2'd2;

    localparam logic [PC_W-1:0] PC_SKIP_SELECT = 5'd3;
    localparam logic [PC_W-1:0] PC_LBA28 = 5'd15;
    localparam logic [PC_W-1:0] PC_CHS = 5'd21;
    localparam logic [PC_W-1:0] PC_REJECT = 5'd29;

    typedef struct packed {
        logic drive;
        logic [ADDR_W-1:0] block_address;
    } t_in;

    typedef struct packed {
        logic [2:0] reg_offset;
        logic [7:0] reg_value;
        logic rejected;
        logic last;
    } t_out;

    typedef enum logic [1:0] {
        OP_EMIT,
        OP_JUMP,
        OP_DIV_CYL,
        OP_DIV_HEAD
    } t_op;

    typedef enum logic [1:0] {
        COND_REJECT,
        COND_SAME_DRIVE,
        COND_CHS,
        COND_LBA28
    } t_cond;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_ONE,
        SRC_DH,
        SRC_DH_A24,
        SRC_DH_HEAD,
        SRC_A0,
        SRC_A8,
        SRC_A16,
        SRC_A24,
        SRC_A32,
        SRC_A40,
        SRC_SEC,
        SRC_CYL_LO,
        SRC_CYL_HI,
        SRC_CMD48,
        SRC_CMD28
    } t_src;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_DIVWAIT
    } t_seq_state;

    typedef struct packed {
        t_op op;
        t_cond cond;
        logic [PC_W-1:0] target;
        logic [2:0] offset;
        t_src src;
        logic rejected;
        logic last;
        logic sel_upd;
    } t_cw;

    typedef struct packed {
        logic reject;
        logic same_drive;
        logic chs;
        logic lba28;
    } t_flags;

    typedef struct packed {
        logic ready;
        logic emit;
        logic div_start;
        logic div_head;
        logic div_cap;
        logic sel_upd;
        logic [2:0] offset;
        t_src src;
        logic rejected;
        logic last;
    } t_seq_ctrl;

    function automatic t_cw cw_emit(input logic [2:0] off, input t_src src,
                                    input logic last, input logic sel_upd);
        t_cw w;
        w.op = OP_EMIT;
        w.cond = COND_REJECT;
        w.target = '0;
        w.offset = off;
        w.src = src;
        w.rejected = 1'b0;
        w.last = last;
        w.sel_upd = sel_upd;
        return w;
    endfunction

    function automatic t_cw cw_jump(input t_cond cond, input logic [PC_W-1:0] target);
        t_cw w;
        w = cw_emit(TF_NONE, SRC_ZERO, 1'b0, 1'b0);
        w.op = OP_JUMP;
        w.cond = cond;
        w.target = target;
        return w;
    endfunction

    function automatic t_cw cw_div(input t_op op);
        t_cw w;
        w = cw_emit(TF_NONE, SRC_ZERO, 1'b0, 1'b0);
        w.op = op;
        return w;
    endfunction

    function automatic t_cw cw_reject();
        t_cw w;
        w = cw_emit(TF_NONE, SRC_ZERO, 1'b1, 1'b0);
        w.rejected = 1'b1;
        return w;
    endfunction

    function automatic t_cw atapio_ucode(input logic [PC_W-1:0] pc);
        t_cw w;
        case (pc)
            5'd0: w = cw_jump(COND_REJECT, PC_REJECT);
            5'd1: w = cw_jump(COND_SAME_DRIVE, PC_SKIP_SELECT);
            5'd2: w = cw_emit(TF_DRIVE_HEAD, SRC_DH, 1'b0, 1'b1);
            5'd3: w = cw_jump(COND_CHS, PC_CHS);
            5'd4: w = cw_jump(COND_LBA28, PC_LBA28);
            5'd5: w = cw_emit(TF_DRIVE_HEAD, SRC_DH, 1'b0, 1'b0);
            5'd6: w = cw_emit(TF_SECCOUNT, SRC_ZERO, 1'b0, 1'b0);
            5'd7: w = cw_emit(TF_LBA_LO, SRC_A24, 1'b0, 1'b0);
            5'd8: w = cw_emit(TF_LBA_MID, SRC_A32, 1'b0, 1'b0);
            5'd9: w = cw_emit(TF_LBA_HI, SRC_A40, 1'b0, 1'b0);
            5'd10: w = cw_emit(TF_SECCOUNT, SRC_ONE, 1'b0, 1'b0);
            5'd11: w = cw_emit(TF_LBA_LO, SRC_A0, 1'b0, 1'b0);
            5'd12: w = cw_emit(TF_LBA_MID, SRC_A8, 1'b0, 1'b0);
            5'd13: w = cw_emit(TF_LBA_HI, SRC_A16, 1'b0, 1'b0);
            5'd14: w = cw_emit(TF_COMMAND, SRC_CMD48, 1'b1, 1'b0);
            5'd15: w = cw_emit(TF_DRIVE_HEAD, SRC_DH_A24, 1'b0, 1'b0);
            5'd16: w = cw_emit(TF_SECCOUNT, SRC_ONE, 1'b0, 1'b0);
            5'd17: w = cw_emit(TF_LBA_LO, SRC_A0, 1'b0, 1'b0);
            5'd18: w = cw_emit(TF_LBA_MID, SRC_A8, 1'b0, 1'b0);
            5'd19: w = cw_emit(TF_LBA_HI, SRC_A16, 1'b0, 1'b0);
            5'd20: w = cw_emit(TF_COMMAND, SRC_CMD28, 1'b1, 1'b0);
            5'd21: w = cw_div(OP_DIV_CYL);
            5'd22: w = cw_div(OP_DIV_HEAD);
            5'd23: w = cw_emit(TF_DRIVE_HEAD, SRC_DH_HEAD, 1'b0, 1'b0);
            5'd24: w = cw_emit(TF_SECCOUNT, SRC_ONE, 1'b0, 1'b0);
            5'd25: w = cw_emit(TF_LBA_LO, SRC_SEC, 1'b0, 1'b0);
            5'd26: w = cw_emit(TF_LBA_MID, SRC_CYL_LO, 1'b0, 1'b0);
            5'd27: w = cw_emit(TF_LBA_HI, SRC_CYL_HI, 1'b0, 1'b0);
            5'd28: w = cw_emit(TF_COMMAND, SRC_CMD28, 1'b1, 1'b0);
            default: w = cw_reject();
        endcase
        return w;
    endfunction

endpackage

/* rtl/atapio_div.sv */
module atapio_div
    import atapio_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [ADDR_W-1:0]   i_dividend,
    input  logic [SPC_W-1:0]    i_divisor,
    input  logic [STEP_W-1:0]   i_steps,
    output logic                o_done,
    output logic [ADDR_W-1:0]   o_quotient,
    output logic [SPC_W-1:0]    o_remainder
);

    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;
    logic [STEP_W-1:0]   r_last;
    logic [ADDR_W-1:0]   r_q;
    logic [SPC_W-1:0]    r_r;
    logic [SPC_W-1:0]    r_d;
    logic [SPC_W:0]      trial;
    logic [SPC_W+1:0]    diff;
    logic                ge;

    assign trial = {r_r, r_q[ADDR_W-1]};
    assign diff = {1'b0, trial} - {2'b00, r_d};
    assign ge = ~diff[SPC_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == r_last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
            r_last <= i_steps - 6'd1;
        end else if (r_busy) begin
            r_q <= {r_q[ADDR_W-2:0], ge};
            r_r <= ge ? diff[SPC_W-1:0] : trial[SPC_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quotient = r_q;
    assign o_remainder = r_r;

endmodule

/* rtl/atapio_seq.sv */
module atapio_seq
    import atapio_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_flags      i_flags,
    input  logic        i_out_free,
    input  logic        i_div_done,
    output t_seq_ctrl   o_ctrl
);

    t_seq_state        r_state;
    t_seq_state        n_state;
    logic [PC_W-1:0]   r_pc;
    logic [PC_W-1:0]   n_pc;
    t_cw               cw;
    logic              hit;

    assign cw = atapio_ucode(r_pc);

    always_comb begin
        case (cw.cond)
            COND_REJECT: hit = i_flags.reject;
            COND_SAME_DRIVE: hit = i_flags.same_drive;
            COND_CHS: hit = i_flags.chs;
            COND_LBA28: hit = i_flags.lba28;
            default: hit = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc = r_pc;
        case (r_state)
            SQ_IDLE: begin
                if (i_start) begin
                    n_state = SQ_RUN;
                    n_pc = '0;
                end
            end
            SQ_RUN: begin
                case (cw.op)
                    OP_JUMP: begin
                        n_pc = hit ? cw.target : r_pc + 5'd1;
                    end
                    OP_EMIT: begin
                        if (i_out_free) begin
                            if (cw.last) begin
                                n_state = SQ_IDLE;
                            end else begin
                                n_pc = r_pc + 5'd1;
                            end
                        end
                    end
                    default: begin
                        n_state = SQ_DIVWAIT;
                    end
                endcase
            end
            SQ_DIVWAIT: begin
                if (i_div_done) begin
                    n_state = SQ_RUN;
                    n_pc = r_pc + 5'd1;
                end
            end
            default: n_state = SQ_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.ready = (r_state == SQ_IDLE);
        o_ctrl.emit = (r_state == SQ_RUN) && (cw.op == OP_EMIT) && i_out_free;
        o_ctrl.div_start = (r_state == SQ_RUN) && (cw.op inside {OP_DIV_CYL, OP_DIV_HEAD});
        o_ctrl.div_head = (cw.op == OP_DIV_HEAD);
        o_ctrl.div_cap = (r_state == SQ_DIVWAIT) && i_div_done;
        o_ctrl.sel_upd = cw.sel_upd;
        o_ctrl.offset = cw.offset;
        o_ctrl.src = cw.src;
        o_ctrl.rejected = cw.rejected;
        o_ctrl.last = cw.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SQ_IDLE;
            r_pc <= '0;
        end else begin
            r_state <= n_state;
            r_pc <= n_pc;
        end
    end

endmodule

/* rtl/ata_pio_read_taskfile_sequencer.sv */
// ATA PIO one-sector read task-file sequencer for one channel.
// Input channel (i_in_valid / o_in_ready, i_in_data): one transaction is one
// read request, a drive number and a 48-bit logical block address.
// Output channel (o_out_valid / i_out_ready, o_out_data): one transaction is
// one task-file register write (offset, byte), or a single rejected result
// when the address is at or past the drive's capacity. last marks the final
// transaction of a request.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data at once;
// write only while no request is in progress.
// A microcode program steps one control word per cycle, but it holds on an
// emitted write while the output register is occupied and waits in a
// separate state while the divider runs. For CHS a bit-serial divider runs 48
// steps for the cylinder and 13 for head and sector.
// When the receiver stalls, the sequencer holds on the pending write; the next
// request is accepted as soon as the last result sits in the output register.
// Reset restores the default geometry, clears modes and capacities, and marks
// no drive as selected.
module ata_pio_read_taskfile_sequencer
    import atapio_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [1:0]          r_mode0;
    logic [1:0]          r_mode1;
    logic [ADDR_W-1:0]   r_cap0;
    logic [ADDR_W-1:0]   r_cap1;
    logic [4:0]          r_heads0;
    logic [4:0]          r_heads1;
    logic [7:0]          r_spt0;
    logic [7:0]          r_spt1;
    logic [1:0]          r_sel;

    logic                r_drv;
    logic [ADDR_W-1:0]   r_lba;
    logic [15:0]         r_cyl;
    logic [SPC_W-1:0]    r_rem;
    logic [3:0]          r_head;
    logic [7:0]          r_sec;

    logic                r_out_valid;
    t_out                r_out;

    logic [1:0]          mode;
    logic [ADDR_W-1:0]   cap;
    logic [4:0]          heads;
    logic [7:0]          spt;
    logic [12:0]         spc_full;
    logic [7:0]          dh;
    logic [7:0]          value;
    logic                accept;
    logic                out_free;
    t_flags              flags;
    t_seq_ctrl           ctrl;
    logic                div_done;
    logic [ADDR_W-1:0]   div_q;
    logic [SPC_W-1:0]    div_r;
    logic [ADDR_W-1:0]   div_dividend;
    logic [SPC_W-1:0]    div_divisor;
    logic [STEP_W-1:0]   div_steps;

    assign accept = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = ctrl.ready;

    assign mode = r_drv ? r_mode1 : r_mode0;
    assign cap = r_drv ? r_cap1 : r_cap0;
    assign heads = (r_drv ? r_heads1 : r_heads0) == 5'd0 ? 5'd1 :
                   (r_drv ? r_heads1 : r_heads0);
    assign spt = (r_drv ? r_spt1 : r_spt0) == 8'd0 ? 8'd1 : (r_drv ? r_spt1 : r_spt0);
    assign spc_full = 13'(spt) * 13'(heads);
    assign dh = (r_drv ? DH_SLAVE : DH_MASTER) | ((mode != MODE_CHS) ? DH_LBA : 8'h00);

    assign flags.reject = (r_lba >= cap);
    assign flags.same_drive = (r_sel == {1'b0, r_drv});
    assign flags.chs = (mode == MODE_CHS);
    assign flags.lba28 = (mode == MODE_LBA28);

    atapio_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_flags    (flags),
        .i_out_free (out_free),
        .i_div_done (div_done),
        .o_ctrl     (ctrl)
    );

    assign div_dividend = ctrl.div_head ? {r_rem, {(ADDR_W-SPC_W){1'b0}}} : r_lba;
    assign div_divisor = ctrl.div_head ? {{(SPC_W-8){1'b0}}, spt} : spc_full[SPC_W-1:0];
    assign div_steps = ctrl.div_head ? DIV_SHORT_STEPS : DIV_LONG_STEPS;

    atapio_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (ctrl.div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .i_steps     (div_steps),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_comb begin
        case (ctrl.src)
            SRC_ZERO: value = 8'h00;
            SRC_ONE: value = 8'h01;
            SRC_DH: value = dh;
            SRC_DH_A24: value = dh | {4'h0, r_lba[27:24]};
            SRC_DH_HEAD: value = dh | {4'h0, r_head};
            SRC_A0: value = r_lba[7:0];
            SRC_A8: value = r_lba[15:8];
            SRC_A16: value = r_lba[23:16];
            SRC_A24: value = r_lba[31:24];
            SRC_A32: value = r_lba[39:32];
            SRC_A40: value = r_lba[47:40];
            SRC_SEC: value = r_sec;
            SRC_CYL_LO: value = r_cyl[7:0];
            SRC_CYL_HI: value = r_cyl[15:8];
            SRC_CMD48: value = CMD_READ_EXT;
            SRC_CMD28: value = CMD_READ;
            default: value = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode0 <= 2'd0;
            r_mode1 <= 2'd0;
            r_cap0 <= '0;
            r_cap1 <= '0;
            r_heads0 <= 5'd16;
            r_heads1 <= 5'd16;
            r_spt0 <= 8'd63;
            r_spt1 <= 8'd63;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DRIVE0_MODE: r_mode0 <= i_cfg_data[1:0];
                CFG_DRIVE1_MODE: r_mode1 <= i_cfg_data[1:0];
                CFG_DRIVE0_CAPACITY: r_cap0 <= i_cfg_data[ADDR_W-1:0];
                CFG_DRIVE1_CAPACITY: r_cap1 <= i_cfg_data[ADDR_W-1:0];
                CFG_DRIVE0_HEADS: r_heads0 <= i_cfg_data[4:0];
                CFG_DRIVE0_TRACK_SECTORS: r_spt0 <= i_cfg_data[7:0];
                CFG_DRIVE1_HEADS: r_heads1 <= i_cfg_data[4:0];
                CFG_DRIVE1_TRACK_SECTORS: r_spt1 <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= SEL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (ctrl.emit && ctrl.sel_upd) begin
                r_sel <= {1'b0, r_drv};
            end
            if (ctrl.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_drv <= i_in_data.drive;
            r_lba <= i_in_data.block_address;
        end
        if (ctrl.div_cap && !ctrl.div_head) begin
            r_cyl <= div_q[15:0];
            r_rem <= div_r;
        end
        if (ctrl.div_cap && ctrl.div_head) begin
            r_head <= div_q[3:0];
            r_sec <= div_r[7:0] + 8'd1;
        end
        if (ctrl.emit) begin
            r_out.reg_offset <= ctrl.offset;
            r_out.reg_value <= value;
            r_out.rejected <= ctrl.rejected;
            r_out.last <= ctrl.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.emit |-> (!r_out_valid || i_out_ready))
        else $error("write issued while output register is occupied");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("sequencer ready right after accepting a request");

    a_sel_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel != 2'd3)
        else $error("selected drive holds an invalid code");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.rejected) |-> o_out_data.last)
        else $error("rejected result not marked last");

endmodule

/* verif/tb_top.sv */
module tb_top;
    import atapio_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int PRINT_LIMIT = 40;
    localparam int PLAN_LEN = 32;

    localparam logic [1:0] MODE_LBA48 = 2'd2;
    localparam logic [1:0] MODE_LBA48_ALT = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;
    localparam t_out REJECT_RESULT = '{TF_NONE, 8'h00, 1'b1, 1'b1};

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} t_row_kind;

    typedef struct packed {
        t_row_kind row_kind;
        logic [2:0] cfg_index;
        logic drive;
        logic [ADDR_W-1:0] value;
        logic rejects;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = CFG_DRIVE0_MODE;
    logic [CFG_W-1:0] i_cfg_data = '0;

    logic reject_known = 1'b0;
    bit steady_flow = 1'b0;
    bit hold_off_due = 1'b0;

    logic [1:0] mode_cfg [2] = '{MODE_CHS, MODE_CHS};
    logic [ADDR_W-1:0] cap_cfg [2] = '{'0, '0};
    logic [4:0] heads_cfg [2] = '{5'd16, 5'd16};
    logic [7:0] spt_cfg [2] = '{8'd63, 8'd63};
    logic [1:0] active_drive = SEL_NONE;

    t_out expected_writes [$];
    int requests_taken = 0;
    int writes_checked = 0;
    int rejects_seen = 0;
    int register_writes = 0;
    int settings_applied = 0;
    int mismatches = 0;
    int cycle_count = 0;

    t_plan_row directed_plan [PLAN_LEN] = '{
        '{ROW_REQUEST, '0, 1'b0, 48'h0, 1'b1},
        '{ROW_REQUEST, '0, 1'b1, ADDR_MAX, 1'b1},
        '{ROW_CONFIG, CFG_DRIVE0_MODE, 1'b0, ADDR_W'(MODE_LBA48), 1'b0},
        '{ROW_CONFIG, CFG_DRIVE0_CAPACITY, 1'b0, ADDR_MAX, 1'b0},
        '{ROW_CONFIG, CFG_DRIVE1_MODE, 1'b0, ADDR_W'(MODE_LBA28), 1'b0},
        '{ROW_CONFIG, CFG_DRIVE1_CAPACITY, 1'b0, ADDR_MAX, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, 48'h0, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, 48'hFFFF_FFFF_FFFE, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, ADDR_MAX, 1'b1},
        '{ROW_REQUEST, '0, 1'b1, 48'h0000_0FFF_FFFF, 1'b0},
        '{ROW_REQUEST, '0, 1'b1, 48'hA5A5_5A5A_A5A5, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, 48'h5A5A_A5A5_5A5A, 1'b0},
        '{ROW_CONFIG, CFG_DRIVE0_MODE, 1'b0, ADDR_W'(MODE_CHS), 1'b0},
        '{ROW_CONFIG, CFG_DRIVE1_MODE, 1'b0, ADDR_W'(MODE_LBA48_ALT), 1'b0},
        '{ROW_CONFIG, CFG_DRIVE1_CAPACITY, 1'b0, 48'd1000, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, 48'd0, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, 48'd1007, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, 48'hFFFF_FFFF_FFFE, 1'b0},
        '{ROW_REQUEST, '0, 1'b1, 48'd999, 1'b0},
        '{ROW_REQUEST, '0, 1'b1, 48'd1000, 1'b1},
        '{ROW_CONFIG, CFG_DRIVE0_HEADS, 1'b0, 48'd0, 1'b0},
        '{ROW_CONFIG, CFG_DRIVE0_TRACK_SECTORS, 1'b0, 48'd0, 1'b0},
        '{ROW_CONFIG, CFG_DRIVE1_MODE, 1'b0, ADDR_W'(MODE_CHS), 1'b0},
        '{ROW_CONFIG, CFG_DRIVE1_HEADS, 1'b0, 48'd31, 1'b0},
        '{ROW_CONFIG, CFG_DRIVE1_TRACK_SECTORS, 1'b0, 48'd255, 1'b0},
        '{ROW_CONFIG, CFG_DRIVE1_CAPACITY, 1'b0, ADDR_MAX, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, 48'h1234_5678_9ABC, 1'b0},
        '{ROW_REQUEST, '0, 1'b1, 48'hFFFF_FFFF_FFFE, 1'b0},
        '{ROW_REQUEST, '0, 1'b1, 48'd5107, 1'b0},
        '{ROW_CONFIG, CFG_DRIVE0_HEADS, 1'b0, 48'd16, 1'b0},
        '{ROW_CONFIG, CFG_DRIVE0_TRACK_SECTORS, 1'b0, 48'd255, 1'b0},
        '{ROW_REQUEST, '0, 1'b0, 48'd4079, 1'b0}
    };

    ata_pio_read_taskfile_sequencer dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    function automatic void add_result(input logic [2:0] off, input logic [7:0] val,
                                       input logic last);
        t_out r;
        r.reg_offset = off;
        r.reg_value = val;
        r.rejected = 1'b0;
        r.last = last;
        expected_writes.push_back(r);
    endfunction

    function automatic void predict_taskfile_writes(input t_in req);
        logic d;
        logic [1:0] mode;
        logic [ADDR_W-1:0] lba;
        logic [7:0] dh;
        logic [63:0] full, heads, spt, spc, head, cyl, sec;
        d = req.drive;
        lba = req.block_address;
        mode = mode_cfg[d];
        if (lba >= cap_cfg[d]) begin
            expected_writes.push_back(REJECT_RESULT);
            return;
        end
        dh = d ? DH_SLAVE : DH_MASTER;
        if (mode != MODE_CHS) dh = dh | DH_LBA;
        if (active_drive != {1'b0, d}) begin
            add_result(TF_DRIVE_HEAD, dh, 1'b0);
            active_drive = {1'b0, d};
        end
        if (mode == MODE_LBA28) begin
            add_result(TF_DRIVE_HEAD, dh | {4'h0, lba[27:24]}, 1'b0);
            add_result(TF_SECCOUNT, 8'h01, 1'b0);
            add_result(TF_LBA_LO, lba[7:0], 1'b0);
            add_result(TF_LBA_MID, lba[15:8], 1'b0);
            add_result(TF_LBA_HI, lba[23:16], 1'b0);
            add_result(TF_COMMAND, CMD_READ, 1'b1);
        end else if (mode == MODE_CHS) begin
            full = {16'd0, lba};
            heads = (heads_cfg[d] == 5'd0) ? 64'd1 : {59'd0, heads_cfg[d]};
            spt = (spt_cfg[d] == 8'd0) ? 64'd1 : {56'd0, spt_cfg[d]};
            spc = heads * spt;
            head = (full % spc) / spt;
            cyl = full / spc;
            sec = (full % spt) + 64'd1;
            add_result(TF_DRIVE_HEAD, dh | {4'h0, head[3:0]}, 1'b0);
            add_result(TF_SECCOUNT, 8'h01, 1'b0);
            add_result(TF_LBA_LO, sec[7:0], 1'b0);
            add_result(TF_LBA_MID, cyl[7:0], 1'b0);
            add_result(TF_LBA_HI, cyl[15:8], 1'b0);
            add_result(TF_COMMAND, CMD_READ, 1'b1);
        end else begin
            add_result(TF_DRIVE_HEAD, dh, 1'b0);
            add_result(TF_SECCOUNT, 8'h00, 1'b0);
            add_result(TF_LBA_LO, lba[31:24], 1'b0);
            add_result(TF_LBA_MID, lba[39:32], 1'b0);
            add_result(TF_LBA_HI, lba[47:40], 1'b0);
            add_result(TF_SECCOUNT, 8'h01, 1'b0);
            add_result(TF_LBA_LO, lba[7:0], 1'b0);
            add_result(TF_LBA_MID, lba[15:8], 1'b0);
            add_result(TF_LBA_HI, lba[23:16], 1'b0);
            add_result(TF_COMMAND, CMD_READ_EXT, 1'b1);
        end
    endfunction

    function automatic logic [CFG_W-1:0] random_mode();
        case ($urandom_range(0, 7))
            0, 1, 2: return CFG_W'(MODE_CHS);
            3, 4: return CFG_W'(MODE_LBA28);
            5, 6: return CFG_W'(MODE_LBA48);
            default: return CFG_W'(MODE_LBA48_ALT);
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] random_capacity();
        int r;
        r = $urandom_range(0, 19);
        if (r < 11) return ADDR_MAX;
        if (r < 16) return rand48();
        if (r < 19) return CFG_W'($urandom_range(1, 5000));
        return '0;
    endfunction

    function automatic logic [CFG_W-1:0] random_heads();
        if ($urandom_range(0, 9) < 8) return CFG_W'($urandom_range(1, 16));
        return CFG_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [CFG_W-1:0] random_track_sectors();
        case ($urandom_range(0, 9))
            7: return CFG_W'(0);
            8: return CFG_W'(1);
            9: return CFG_W'(255);
            default: return CFG_W'($urandom_range(1, 255));
        endcase
    endfunction

    task automatic write_register(input logic [2:0] index, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        case (index)
            CFG_DRIVE0_MODE: mode_cfg[0] = data[1:0];
            CFG_DRIVE1_MODE: mode_cfg[1] = data[1:0];
            CFG_DRIVE0_CAPACITY: cap_cfg[0] = data[ADDR_W-1:0];
            CFG_DRIVE1_CAPACITY: cap_cfg[1] = data[ADDR_W-1:0];
            CFG_DRIVE0_HEADS: heads_cfg[0] = data[4:0];
            CFG_DRIVE0_TRACK_SECTORS: spt_cfg[0] = data[7:0];
            CFG_DRIVE1_HEADS: heads_cfg[1] = data[4:0];
            CFG_DRIVE1_TRACK_SECTORS: spt_cfg[1] = data[7:0];
            default: ;
        endcase
        register_writes++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, drain every outstanding write, then let the sequencer go idle
    task automatic quiesce();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_writes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_request(input logic drive, input logic [ADDR_W-1:0] addr,
                                input logic known_reject, input int gap);
        i_in_valid <= 1'b1;
        i_in_data <= {drive, addr};
        reject_known <= known_reject;
        do @(posedge i_clk); while (!o_in_ready);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic pick_request(output logic drive, output logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] cap;
        int r;
        drive = 1'($urandom_range(0, 1));
        cap = cap_cfg[drive];
        r = $urandom_range(0, 99);
        if (cap != '0 && r < 85) addr = rand48() % cap;
        else if (r < 92) addr = cap;
        else addr = rand48();
    endtask

    task automatic randomize_registers();
        write_register(CFG_DRIVE0_MODE, random_mode());
        write_register(CFG_DRIVE1_MODE, random_mode());
        write_register(CFG_DRIVE0_CAPACITY, random_capacity());
        write_register(CFG_DRIVE1_CAPACITY, random_capacity());
        write_register(CFG_DRIVE0_HEADS, random_heads());
        write_register(CFG_DRIVE0_TRACK_SECTORS, random_track_sectors());
        write_register(CFG_DRIVE1_HEADS, random_heads());
        write_register(CFG_DRIVE1_TRACK_SECTORS, random_track_sectors());
        settings_applied++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            requests_taken++;
            if (reject_known) expected_writes.push_back(REJECT_RESULT);
            else predict_taskfile_writes(i_in_data);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            writes_checked++;
            if (o_out_data.rejected) rejects_seen++;
            if (expected_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= PRINT_LIMIT)
                    $display("%0t: unexpected transaction offset %0d value %02h rej %0b last %0b",
                             $time, o_out_data.reg_offset, o_out_data.reg_value,
                             o_out_data.rejected, o_out_data.last);
            end else begin
                want = expected_writes.pop_front();
                if (o_out_data.reg_offset !== want.reg_offset ||
                    o_out_data.reg_value !== want.reg_value ||
                    o_out_data.rejected !== want.rejected ||
                    o_out_data.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= PRINT_LIMIT)
                        $display({"%0t: mismatch expected off %0d val %02h rej %0b last %0b,",
                                  " got off %0d val %02h rej %0b last %0b"},
                                 $time, want.reg_offset, want.reg_value, want.rejected,
                                 want.last, o_out_data.reg_offset, o_out_data.reg_value,
                                 o_out_data.rejected, o_out_data.last);
                end
            end
        end
    end

    initial begin : receiver
        int run;
        forever begin
            if (hold_off_due) begin
                hold_off_due = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            run = steady_flow ? 16 : $urandom_range(1, 8);
            repeat (run) @(posedge i_clk);
            run = steady_flow ? 0 : pick_gap();
            if (run > 0) begin
                i_out_ready <= 1'b0;
                repeat (run) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d writes outstanding",
                 cycle_count, expected_writes.size());
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        t_plan_row row;
        logic drv;
        logic [ADDR_W-1:0] addr;
        bit configuring;
        configuring = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            row = directed_plan[i];
            if (row.row_kind == ROW_CONFIG) begin
                if (!configuring) begin
                    quiesce();
                    settings_applied++;
                end
                configuring = 1'b1;
                write_register(row.cfg_index, row.value);
            end else begin
                configuring = 1'b0;
                send_request(row.drive, row.value, row.rejects, pick_gap());
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiesce();
            randomize_registers();
            steady_flow = (p == 2);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // stall the output long enough to back up the input
                if (p == 5 && n == 10) hold_off_due = 1'b1;
                pick_request(drv, addr);
                send_request(drv, addr, 1'b0, steady_flow ? 0 : pick_gap());
            end
        end
        steady_flow = 1'b0;
        quiesce();

        $display("covered %0d read requests over %0d register settings: %0d transactions, %0d rejected",
                 requests_taken, settings_applied, writes_checked, rejects_seen);
        $display("all addressing modes, capacity edges, CHS geometry extremes and a %0d-cycle stall",
                 HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
